FILE: hw/rtl/vertex_record_size_calc_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex record size calculator
// Shorthands for clocked concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef VERTEX_RECORD_SIZE_CALC_ASSERT_SVH
`define VERTEX_RECORD_SIZE_CALC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRSC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VRSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/vrsc_pkg.sv
// ----------------------------------------------------------------------------
// Vertex record size calculator package
// Types, tables and small decode functions shared by the size pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vrsc_pkg;

	// Presence type of one attribute in the vertex descriptor.
	typedef enum logic [1:0] {
		PRES_NONE   = 2'd0,
		PRES_DIRECT = 2'd1,
		PRES_IDX8   = 2'd2,
		PRES_IDX16  = 2'd3
	} presence_t;

	// Component format code for float data.
	localparam logic [2:0] FMT_FLOAT = 3'd4;
	localparam logic [2:0] FMT_U16   = 3'd2;

	localparam int NUM_TEX = 8;
	localparam int NUM_MTX = 9;

	// Direct size of one colour, indexed by the colour format.
	localparam logic [2:0] COLOUR_BYTES [8] = '{
		3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0
	};

	// Per-attribute byte counts of one vertex, from the decode stage.
	typedef struct packed {
		logic [3:0]                mtx_count;
		logic [3:0]                pos;
		logic [5:0]                nrm;
		logic [2:0]                col0;
		logic [2:0]                col1;
		logic [NUM_TEX-1:0][3:0]   tex;
	} elem_sizes_t;

	function automatic logic [2:0] comp_bytes(input logic [2:0] code);
		logic [2:0] r;
		if (code == FMT_FLOAT) begin
			r = 3'd4;
		end else if (code >= FMT_U16) begin
			r = 3'd2;
		end else begin
			r = 3'd1;
		end
		return r;
	endfunction

	// Bytes an attribute adds for its presence type and its direct size.
	function automatic logic [5:0] pres_bytes(input logic [1:0] kind,
		input logic [5:0] direct);
		logic [5:0] r;
		case (presence_t'(kind))
			PRES_NONE:   r = 6'd0;
			PRES_DIRECT: r = direct;
			PRES_IDX8:   r = 6'd1;
			PRES_IDX16:  r = 6'd2;
			default:     r = 6'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vrsc_elem_decode.sv
// ----------------------------------------------------------------------------
// Vertex attribute size decode
// Turns the descriptor and format words into per-attribute byte counts.
// ----------------------------------------------------------------------------
`default_nettype none

module vrsc_elem_decode
	import vrsc_pkg::*;
(
	input  wire logic [15:0] descriptor_high,
	input  wire logic [16:0] descriptor_low,
	input  wire logic [31:0] format_word_a,
	input  wire logic [31:0] format_word_b,
	input  wire logic [31:0] format_word_c,
	output elem_sizes_t      sizes
);

	logic [3:0] tex_fmt [NUM_TEX];
	logic [2:0] pos_comp;
	logic [2:0] nrm_comp;
	logic [5:0] pos_direct;
	logic [5:0] nrm_direct;
	logic [5:0] nrm_base;
	logic [1:0] nrm_kind;
	logic       nrm_nine;

	// Each texture coordinate: count bit in the low position, format above it.
	assign tex_fmt[0] = format_word_a[24:21];
	assign tex_fmt[1] = format_word_b[3:0];
	assign tex_fmt[2] = format_word_b[12:9];
	assign tex_fmt[3] = format_word_b[21:18];
	assign tex_fmt[4] = format_word_b[30:27];
	assign tex_fmt[5] = format_word_c[8:5];
	assign tex_fmt[6] = format_word_c[17:14];
	assign tex_fmt[7] = format_word_c[26:23];

	assign pos_comp = comp_bytes(format_word_a[3:1]);
	assign nrm_comp = comp_bytes(format_word_a[12:10]);
	assign nrm_kind = descriptor_low[12:11];
	assign nrm_nine = format_word_a[9];

	assign pos_direct = format_word_a[0] ? (6'(pos_comp) * 6'd3) : (6'(pos_comp) * 6'd2);
	assign nrm_direct = nrm_nine ? (6'(nrm_comp) * 6'd9) : (6'(nrm_comp) * 6'd3);
	assign nrm_base   = pres_bytes(nrm_kind, nrm_direct);

	always_comb begin
		logic [3:0] cnt;
		logic [2:0] tc;
		cnt = 4'd0;
		for (int i = 0; i < NUM_MTX; i++) begin
			cnt = cnt + 4'(descriptor_low[i]);
		end
		sizes.mtx_count = cnt;
		sizes.pos = 4'(pres_bytes(descriptor_low[10:9], pos_direct));
		// A three-index normal carries two more indices of the same width.
		if (nrm_kind[1] && nrm_nine && format_word_a[31]) begin
			sizes.nrm = nrm_base + (nrm_kind[0] ? 6'd4 : 6'd2);
		end else begin
			sizes.nrm = nrm_base;
		end
		sizes.col0 = 3'(pres_bytes(descriptor_low[14:13],
			6'(COLOUR_BYTES[format_word_a[16:14]])));
		sizes.col1 = 3'(pres_bytes(descriptor_low[16:15],
			6'(COLOUR_BYTES[format_word_a[20:18]])));
		for (int i = 0; i < NUM_TEX; i++) begin
			tc = comp_bytes(tex_fmt[i][3:1]);
			sizes.tex[i] = 4'(pres_bytes(descriptor_high[2*i +: 2],
				tex_fmt[i][0] ? (6'(tc) * 6'd2) : 6'(tc)));
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_record_size_calc.sv
// Vertex record size calculator: takes the two vertex-descriptor words and
// the three attribute-format words of a primitive and returns the byte size
// of one vertex record in the command stream. One transfer is accepted every
// cycle while the result side is not stalled; its result passes through the
// three register stages (attribute decode, two partial sums, final add)
// before it is presented on the master side.
// Each stage holds its item while the next one is full and stalled, so
// back-pressure on the result side loses and repeats nothing.
// ----------------------------------------------------------------------------
// Vertex record size calculator
// Three-stage pipeline from descriptor and format words to record bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_record_size_calc_assert.svh"

module vertex_record_size_calc
	import vrsc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// descriptor_high[15:0], descriptor_low[32:16], format_word_a[64:33],
	// format_word_b[96:65], format_word_c[128:97], zero fill [135:129]
	input  wire logic [135:0] s_tdata,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// vertex_bytes[7:0]
	output      logic [7:0]   m_tdata
);

	elem_sizes_t sizes;
	elem_sizes_t sizes_s1;
	logic        vld_s1, vld_s2, vld_s3;
	logic        en_s1, en_s2, en_s3;
	logic [6:0]  sum_attr_s2;
	logic [6:0]  sum_tex_s2;
	logic [7:0]  bytes_s3;
	logic [6:0]  sum_attr;
	logic [6:0]  sum_tex;

	vrsc_elem_decode u_decode (
		.descriptor_high (s_tdata[15:0]),
		.descriptor_low  (s_tdata[32:16]),
		.format_word_a   (s_tdata[64:33]),
		.format_word_b   (s_tdata[96:65]),
		.format_word_c   (s_tdata[128:97]),
		.sizes           (sizes)
	);

	// A stage loads when it is empty or its content moves on this cycle.
	assign en_s3    = !vld_s3 || m_tready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= s_tvalid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_comb begin
		sum_attr = 7'(sizes_s1.mtx_count) + 7'(sizes_s1.pos) + 7'(sizes_s1.nrm)
			+ 7'(sizes_s1.col0) + 7'(sizes_s1.col1);
		sum_tex = 7'd0;
		for (int i = 0; i < NUM_TEX; i++) begin
			sum_tex = sum_tex + 7'(sizes_s1.tex[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			sizes_s1 <= sizes;
		end
		if (en_s2 && vld_s1) begin
			sum_attr_s2 <= sum_attr;
			sum_tex_s2  <= sum_tex;
		end
		if (en_s3 && vld_s2) begin
			bytes_s3 <= 8'(sum_attr_s2) + 8'(sum_tex_s2);
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = bytes_s3;

	`VRSC_ASSERT_SAME(a_bytes_bound, m_tvalid, m_tdata <= 8'd129, "record size above 129 bytes")
	`VRSC_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, vld_s1, "accepted transfer not in stage 1")
	`VRSC_ASSERT_NEXT(a_mid_hold, vld_s2 && vld_s3 && !m_tready, vld_s2, "stalled item lost in stage 2")

endmodule

`default_nettype wire
